/* hdl/stl_pkg.sv */
// ----------------------------------------------------------------------------
// stl_pkg: shared types and constants of the script token lexer
// Lexer modes, token kinds, the token record, keyword tables and the small
// byte classification helpers used by the lexer core and the result queue.
// ----------------------------------------------------------------------------
`default_nettype none

package stl_pkg;

  // lexer mode: what kind of token is pending
  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_IDENT,
    MODE_NUM,
    MODE_EQ,
    MODE_BANG,
    MODE_LT,
    MODE_GT
  } mode_t;

  // token kinds as seen on the result channel
  typedef enum logic [4:0] {
    K_EOF,
    K_IDENT,
    K_INT,
    K_ELSE,
    K_FN,
    K_IF,
    K_LET,
    K_WHILE,
    K_LBRACE,
    K_RBRACE,
    K_LPAREN,
    K_RPAREN,
    K_SEMI,
    K_PLUS,
    K_MINUS,
    K_STAR,
    K_SLASH,
    K_ASSIGN,
    K_EQEQ,
    K_NOTEQ,
    K_LESS,
    K_LESSEQ,
    K_GREATER,
    K_GREATEREQ,
    K_ERROR
  } kind_t;

  localparam int SPAN_W = 16;
  localparam int TAG_W  = 16;

  // one result token
  typedef struct packed {
    kind_t             kind;
    logic [SPAN_W-1:0] start_off;
    logic [SPAN_W-1:0] end_off;
    logic [TAG_W-1:0]  tag;
    logic              last;
  } token_t;

  // up to two tokens handed from the core to the queue per request
  typedef struct packed {
    logic [1:0] n;
    token_t     first;
    token_t     second;
  } push_t;

  // result queue sizing
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;
  localparam int Q_CNT_W = 3;

  // keyword tables: else, fn, if, let, while
  localparam int         KW_COUNT = 5;
  localparam logic [4:0] KW_ALL   = 5'b11111;
  localparam logic [2:0] IDENT_LEN_MAX = 3'd7;

  localparam logic [7:0] KW_TEXT [KW_COUNT][8] = '{
    '{"e", "l", "s", "e", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"f", "n", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"l", "e", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"w", "h", "i", "l", "e", 8'h00, 8'h00, 8'h00}
  };
  localparam logic [2:0] KW_LEN  [KW_COUNT] = '{3'd4, 3'd2, 3'd2, 3'd3, 3'd5};
  localparam kind_t      KW_KIND [KW_COUNT] = '{K_ELSE, K_FN, K_IF, K_LET, K_WHILE};

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == 8'h20 || c == 8'h09 || c == 8'h0D || c == 8'h0A;
  endfunction

  // keep the keywords that still match with byte c at position idx
  function automatic logic [4:0] kw_filter(input logic [4:0] cands, input logic [2:0] idx,
                                           input logic [7:0] c);
    logic [4:0] keep;
    keep = '0;
    for (int k = 0; k < KW_COUNT; k++) begin
      keep[k] = cands[k] && (idx < KW_LEN[k]) && (KW_TEXT[k][idx] == c);
    end
    return keep;
  endfunction

  // single byte tokens, anything unknown is an error
  function automatic kind_t punct_kind(input logic [7:0] c);
    kind_t kind;
    case (c)
      "{":     kind = K_LBRACE;
      "}":     kind = K_RBRACE;
      "(":     kind = K_LPAREN;
      ")":     kind = K_RPAREN;
      ";":     kind = K_SEMI;
      "+":     kind = K_PLUS;
      "-":     kind = K_MINUS;
      "*":     kind = K_STAR;
      "/":     kind = K_SLASH;
      default: kind = K_ERROR;
    endcase
    return kind;
  endfunction

  // kind of the pending token when it is closed by a byte that does not extend it
  function automatic kind_t pending_kind(input mode_t mode, input logic [4:0] cands,
                                         input logic [2:0] len);
    kind_t kind;
    logic  found;
    kind  = K_GREATER;
    found = 1'b0;
    case (mode)
      MODE_IDENT: begin
        kind = K_IDENT;
        for (int k = 0; k < KW_COUNT; k++) begin
          if (!found && cands[k] && len == KW_LEN[k]) begin
            kind  = KW_KIND[k];
            found = 1'b1;
          end
        end
      end
      MODE_NUM:  kind = K_INT;
      MODE_EQ:   kind = K_ASSIGN;
      MODE_BANG: kind = K_ERROR;
      MODE_LT:   kind = K_LESS;
      default:   kind = K_GREATER;
    endcase
    return kind;
  endfunction

  // two byte operator closed by '='
  function automatic kind_t pair_kind(input mode_t mode);
    kind_t kind;
    case (mode)
      MODE_EQ:   kind = K_EQEQ;
      MODE_BANG: kind = K_NOTEQ;
      MODE_LT:   kind = K_LESSEQ;
      default:   kind = K_GREATEREQ;
    endcase
    return kind;
  endfunction

endpackage

`default_nettype wire

/* hdl/stl_lex_core.sv */
// ----------------------------------------------------------------------------
// stl_lex_core: lexer state and token decision
// Holds the lexer mode, offsets and keyword tracking, and turns one accepted
// request into zero, one or two tokens for the result queue.
// ----------------------------------------------------------------------------
`default_nettype none

module stl_lex_core
  import stl_pkg::*;
#(
  parameter int OFFSET_BITS = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             acc,
  input  logic             is_end,
  input  logic [7:0]       char_byte,
  input  logic [TAG_W-1:0] tag,
  output push_t            push
);

  mode_t                  mode_r, mode_nxt;
  logic [OFFSET_BITS-1:0] off_r, off_nxt;
  logic [OFFSET_BITS-1:0] tstart_r, tstart_nxt;
  logic [4:0]             cands_r, cands_nxt;
  logic [2:0]             len_r, len_nxt;
  logic [OFFSET_BITS-1:0] off_inc;

  logic   c_alpha, c_digit, c_word, c_space, c_opener;
  logic   cont_ident, cont_num, op_mode, pair_hit;
  logic   a_v, b_v;
  token_t tok_a, tok_b;

  // saturating offset step
  assign off_inc = (&off_r) ? off_r : off_r + 1'b1;

  // byte classes
  assign c_alpha  = is_alpha(char_byte);
  assign c_digit  = is_digit(char_byte);
  assign c_word   = c_alpha || c_digit || char_byte == "_";
  assign c_space  = is_space(char_byte);
  assign c_opener = c_alpha || c_digit || char_byte == "_" || char_byte == "=" ||
                    char_byte == "!" || char_byte == "<" || char_byte == ">";

  // how the byte relates to the pending token
  assign cont_ident = mode_r == MODE_IDENT && c_word;
  assign cont_num   = mode_r == MODE_NUM && c_digit;
  assign op_mode    = mode_r inside {MODE_EQ, MODE_BANG, MODE_LT, MODE_GT};
  assign pair_hit   = op_mode && char_byte == "=";

  // next state
  always_comb begin
    mode_nxt   = mode_r;
    off_nxt    = off_r;
    tstart_nxt = tstart_r;
    cands_nxt  = cands_r;
    len_nxt    = len_r;
    if (acc) begin
      if (is_end) begin
        mode_nxt   = MODE_IDLE;
        off_nxt    = '0;
        tstart_nxt = '0;
        cands_nxt  = KW_ALL;
        len_nxt    = '0;
      end else begin
        off_nxt = off_inc;
        if (cont_ident) begin
          if (len_r < IDENT_LEN_MAX) begin
            cands_nxt = kw_filter(cands_r, len_r, char_byte);
            len_nxt   = len_r + 3'd1;
          end else begin
            cands_nxt = '0;
          end
        end else if (cont_num) begin
          mode_nxt = MODE_NUM;
        end else if (pair_hit) begin
          mode_nxt = MODE_IDLE;
        end else begin
          mode_nxt = MODE_IDLE;
          if (c_alpha || char_byte == "_") begin
            mode_nxt   = MODE_IDENT;
            tstart_nxt = off_r;
            len_nxt    = 3'd1;
            cands_nxt  = kw_filter(KW_ALL, 3'd0, char_byte);
          end else if (c_digit) begin
            mode_nxt   = MODE_NUM;
            tstart_nxt = off_r;
          end else begin
            case (char_byte)
              "=": begin
                mode_nxt   = MODE_EQ;
                tstart_nxt = off_r;
              end
              "!": begin
                mode_nxt   = MODE_BANG;
                tstart_nxt = off_r;
              end
              "<": begin
                mode_nxt   = MODE_LT;
                tstart_nxt = off_r;
              end
              ">": begin
                mode_nxt   = MODE_GT;
                tstart_nxt = off_r;
              end
              default: mode_nxt = MODE_IDLE;
            endcase
          end
        end
      end
    end
  end

  // token outputs: a closes the pending token, b is the fresh byte or eof
  always_comb begin
    a_v = acc && mode_r != MODE_IDLE && (is_end || !(cont_ident || cont_num));
    b_v = acc && (is_end || !(cont_ident || cont_num || pair_hit || c_space || c_opener));

    tok_a.kind      = (pair_hit && !is_end) ? pair_kind(mode_r)
                                            : pending_kind(mode_r, cands_r, len_r);
    tok_a.start_off = SPAN_W'(tstart_r);
    tok_a.end_off   = (pair_hit && !is_end) ? SPAN_W'(off_inc) : SPAN_W'(off_r);
    tok_a.tag       = tag;
    tok_a.last      = !b_v;

    tok_b.kind      = is_end ? K_EOF : punct_kind(char_byte);
    tok_b.start_off = SPAN_W'(off_r);
    tok_b.end_off   = is_end ? SPAN_W'(off_r) : SPAN_W'(off_inc);
    tok_b.tag       = tag;
    tok_b.last      = 1'b1;

    push.n      = {1'b0, a_v} + {1'b0, b_v};
    push.first  = a_v ? tok_a : tok_b;
    push.second = tok_b;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_IDLE;
      off_r    <= '0;
      tstart_r <= '0;
      cands_r  <= KW_ALL;
      len_r    <= '0;
    end else begin
      mode_r   <= mode_nxt;
      off_r    <= off_nxt;
      tstart_r <= tstart_nxt;
      cands_r  <= cands_nxt;
      len_r    <= len_nxt;
    end
  end

`ifndef ASSERT_OFF
  // end of source leaves the lexer idle at offset zero
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    acc && is_end |=> mode_r == MODE_IDLE && off_r == '0)
    else $error("lexer state not cleared after end of source");

  // a pair of tokens marks only the second as last
  a_pair_last: assert property (@(posedge clk) disable iff (!rst_n)
    push.n == 2'd2 |-> push.second.last && !push.first.last)
    else $error("bad last marking on a token pair");

  // nothing pending means at most one token
  a_idle_single: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == MODE_IDLE |-> push.n != 2'd2 && push.n != 2'd3)
    else $error("two tokens from an idle lexer");
`endif

endmodule

`default_nettype wire

/* hdl/stl_out_queue.sv */
// ----------------------------------------------------------------------------
// stl_out_queue: result token queue
// Four entry queue taking up to two tokens per request and giving one per
// cycle to the result channel while out_ready is high; keeps room for a token pair.
// ----------------------------------------------------------------------------
`default_nettype none

module stl_out_queue
  import stl_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  push_t  push,
  output logic   room,
  output logic   out_valid,
  input  logic   out_ready,
  output token_t out_tok
);

  token_t             ent_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] count_r, count_nxt;
  logic [Q_PTR_W-1:0] wr_ptr_2nd;
  logic               pop;

  // status and read side
  assign room       = count_r <= Q_CNT_W'(Q_DEPTH - 2);
  assign out_valid  = count_r != '0;
  assign out_tok    = ent_r[rd_ptr_r];
  assign pop        = out_valid && out_ready;
  assign wr_ptr_2nd = wr_ptr_r + 1'b1;

  // pointer and fill update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + Q_PTR_W'(push.n);
    rd_ptr_nxt = rd_ptr_r + Q_PTR_W'(pop);
    count_nxt  = count_r + Q_CNT_W'(push.n) - Q_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // token storage
  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      ent_r[wr_ptr_r] <= push.first;
    end
    if (push.n == 2'd2) begin
      ent_r[wr_ptr_2nd] <= push.second;
    end
  end

`ifndef ASSERT_OFF
  // fill never exceeds the depth
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= Q_CNT_W'(Q_DEPTH))
    else $error("result queue overfilled");

  // tokens only arrive while a pair still fits
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push.n != 2'd0 |-> room)
    else $error("tokens pushed without room");

  // a lone pop drops the fill by one
  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    pop && push.n == 2'd0 |=> count_r == $past(count_r) - 3'd1)
    else $error("fill count wrong after pop");
`endif

endmodule

`default_nettype wire

/* hdl/script_token_lexer.sv */
// ----------------------------------------------------------------------------
// script_token_lexer: streaming lexer for a small scripting language
// Takes source bytes and an end marker, gives tokens with kind, span and
// source tag; keywords, two byte operators and error tokens included.
//
//   channel  | direction | payload
//   ---------+-----------+------------------------------------------------
//   in_      | sink      | tdata: char_byte; tuser: action (1 = end)
//   out_     | source    | tdata: kind, start, end, tag; tlast: last of run
//   cfg_     | sink      | wr_data: source tag, written when wr_en is high
//
// one request is taken per cycle while in_tready is high; its tokens reach the
// queue the same cycle and the queue head is on out_ from the next cycle on
// a request can cause two tokens, so in_tready drops while fewer than two
// of the four queue entries are free
// stalls on out_ only hold the queue; no token is lost or repeated
// synchronous active low reset: lexer idle, offsets zero, queue empty
// ----------------------------------------------------------------------------
`default_nettype none

module script_token_lexer
  import stl_pkg::*;
#(
  parameter int OFFSET_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_byte
  input  logic        in_tuser,   // [0] action
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // [4:0] token_kind, [20:5] start_off,
                                  // [36:21] end_off, [52:37] span_tag, zero above
  output logic        out_tlast,  // last_of_run
  // configuration
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  logic [TAG_W-1:0] tag_r;
  logic             acc;
  push_t            push;
  token_t           head;

  // source tag register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r <= '0;
    end else if (cfg_wr_en) begin
      tag_r <= cfg_wr_data;
    end
  end

  assign acc = in_tvalid && in_tready;

  // lexer state and token decision
  stl_lex_core #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .is_end    (in_tuser),
    .char_byte (in_tdata),
    .tag       (tag_r),
    .push      (push)
  );

  // result queue
  stl_out_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_tok   (head)
  );

  // result packing
  assign out_tdata = {3'b000, head.tag, head.end_off, head.start_off, head.kind};
  assign out_tlast = head.last;

endmodule

`default_nettype wire

/* tb/tb_script_token_lexer.sv */
// ----------------------------------------------------------------------------
// tb_script_token_lexer: self-checking testbench for the script token lexer
// Streams source bytes and end markers into the lexer, predicts every token
// with a behavioural lexer kept inside the bench, and compares each token
// leaving the result channel with the oldest prediction. Covers odd bytes,
// long identifiers, keywords, operator pairs, random well-formed sources
// with noise, random idling on both sides and a long receiver hold-off that
// fills the result queue.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_script_token_lexer
  import stl_pkg::*;
();

  localparam logic ACT_BYTE = 1'b0;
  localparam logic ACT_END  = 1'b1;

  localparam logic [2:0]  IDENT_CAP   = 3'd7;
  localparam logic [4:0]  KW_ALL_ON   = 5'b11111;
  localparam logic [15:0] OFF_TOP     = 16'hFFFF;
  localparam int          SETTLE      = 4;
  localparam int          CYCLE_LIMIT = 600000;
  localparam int          REPORT_MAX  = 10;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [55:0] out_tdata;
  logic        out_tlast;
  logic        cfg_wr_en;
  logic [15:0] cfg_wr_data;

  // behavioural lexer state
  mode_t       lx_mode;
  logic [15:0] tok_begin;
  logic [15:0] next_off;
  logic [4:0]  kw_live;
  logic [2:0]  id_len;
  logic [15:0] src_tag;

  token_t expected_tokens[$];

  int    mismatches;
  int    reqs_sent;
  int    cycle_count;
  int    tx_idle_pct;
  int    rx_idle_pct;
  int    hold_req;
  string ident_chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
  string punct_chars = "{}();+-*/";
  string op_chars    = "=!<>";

  script_token_lexer i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // run limit
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("status: fail");
    $finish;
  end

  // ---------------------------------------------------------------- lexer

  function automatic string kw_word(input int k);
    case (k)
      0:       return "else";
      1:       return "fn";
      2:       return "if";
      3:       return "let";
      default: return "while";
    endcase
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_numeral(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  // space, tab, cr, lf
  function automatic logic is_blank(input logic [7:0] c);
    return c == 8'h20 || c == 8'h09 || c == 8'h0D || c == 8'h0A;
  endfunction

  function automatic logic [15:0] off_step(input logic [15:0] v);
    return (v == OFF_TOP) ? v : v + 16'd1;
  endfunction

  // keywords that stay possible once byte c sits at position pos
  function automatic logic [4:0] narrow_keywords(input logic [4:0] live, input int pos,
                                                 input logic [7:0] c);
    logic [4:0] keep;
    string      w;
    int         k;
    keep = '0;
    for (k = 0; k < 5; k++) begin
      w = kw_word(k);
      keep[k] = live[k] && (pos < w.len()) && (w[pos] == c);
    end
    return keep;
  endfunction

  // kind of the pending token when something closes it
  function automatic kind_t closing_kind();
    kind_t kind_out;
    string w;
    int    k;
    case (lx_mode)
      MODE_IDENT: begin
        kind_out = K_IDENT;
        // lowest keyword index wins
        for (k = 4; k >= 0; k--) begin
          w = kw_word(k);
          if (kw_live[k] && int'(id_len) == w.len()) kind_out = kind_t'(int'(K_ELSE) + k);
        end
      end
      MODE_NUM:  kind_out = K_INT;
      MODE_EQ:   kind_out = K_ASSIGN;
      MODE_BANG: kind_out = K_ERROR;
      MODE_LT:   kind_out = K_LESS;
      default:   kind_out = K_GREATER;
    endcase
    return kind_out;
  endfunction

  task automatic clear_lexer();
    lx_mode   = MODE_IDLE;
    tok_begin = '0;
    next_off  = '0;
    kw_live   = KW_ALL_ON;
    id_len    = '0;
  endtask

  task automatic push_token(input kind_t kind, input logic [15:0] s, input logic [15:0] e);
    token_t t;
    t.kind      = kind;
    t.start_off = s;
    t.end_off   = e;
    t.tag       = src_tag;
    t.last      = 1'b0;
    expected_tokens = {expected_tokens, t};
  endtask

  // tokens caused by one accepted request
  task automatic predict_tokens(input logic act, input logic [7:0] c);
    logic [15:0] p;
    int          n_before;
    token_t      t;
    kind_t       solo;
    logic        waits;
    p = next_off;
    n_before = expected_tokens.size();
    if (act == ACT_END) begin
      if (lx_mode != MODE_IDLE) push_token(closing_kind(), tok_begin, p);
      push_token(K_EOF, p, p);
      clear_lexer();
    end else begin
      next_off = off_step(p);
      if (lx_mode == MODE_IDENT && (is_letter(c) || is_numeral(c) || c == "_")) begin
        kw_live = narrow_keywords(kw_live, int'(id_len), c);
        if (id_len < IDENT_CAP) id_len++;
        else kw_live = '0;
      end else if (lx_mode == MODE_NUM && is_numeral(c)) begin
        // number carries on
      end else if (lx_mode >= MODE_EQ && lx_mode <= MODE_GT && c == "=") begin
        case (lx_mode)
          MODE_EQ:   solo = K_EQEQ;
          MODE_BANG: solo = K_NOTEQ;
          MODE_LT:   solo = K_LESSEQ;
          default:   solo = K_GREATEREQ;
        endcase
        push_token(solo, tok_begin, off_step(p));
        lx_mode = MODE_IDLE;
      end else begin
        if (lx_mode != MODE_IDLE) begin
          push_token(closing_kind(), tok_begin, p);
          lx_mode = MODE_IDLE;
        end
        // byte with nothing pending
        if (!is_blank(c)) begin
          if (is_letter(c) || c == "_") begin
            lx_mode   = MODE_IDENT;
            tok_begin = p;
            id_len    = 3'd1;
            kw_live   = narrow_keywords(KW_ALL_ON, 0, c);
          end else if (is_numeral(c)) begin
            lx_mode   = MODE_NUM;
            tok_begin = p;
          end else begin
            solo  = K_ERROR;
            waits = 1'b0;
            case (c)
              "=": begin lx_mode = MODE_EQ;   waits = 1'b1; end
              "!": begin lx_mode = MODE_BANG; waits = 1'b1; end
              "<": begin lx_mode = MODE_LT;   waits = 1'b1; end
              ">": begin lx_mode = MODE_GT;   waits = 1'b1; end
              "{": solo = K_LBRACE;
              "}": solo = K_RBRACE;
              "(": solo = K_LPAREN;
              ")": solo = K_RPAREN;
              ";": solo = K_SEMI;
              "+": solo = K_PLUS;
              "-": solo = K_MINUS;
              "*": solo = K_STAR;
              "/": solo = K_SLASH;
              default: solo = K_ERROR;
            endcase
            if (waits) tok_begin = p;
            else push_token(solo, p, off_step(p));
          end
        end
      end
    end
    // flag the final token of this request
    if (expected_tokens.size() > n_before) begin
      t = expected_tokens.pop_back();
      t.last = 1'b1;
      expected_tokens = {expected_tokens, t};
    end
  endtask

  // ---------------------------------------------------------------- monitor

  // register writes, accepted requests and token checks at the rising edge
  always @(posedge clk) begin : token_check
    token_t      want;
    logic [55:0] want_data;
    if (rst_n) begin
      if (cfg_wr_en) src_tag = cfg_wr_data;
      if (in_tvalid && in_tready) predict_tokens(in_tuser, in_tdata);
      if (out_tvalid && out_tready) begin
        if (expected_tokens.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("%0t unexpected token: kind %0d start %0d end %0d tag %h last %b",
                     $time, out_tdata[4:0], out_tdata[20:5], out_tdata[36:21],
                     out_tdata[52:37], out_tlast);
        end else begin
          want = expected_tokens.pop_front();
          want_data = {3'b000, want.tag, want.end_off, want.start_off, want.kind};
          if (out_tdata !== want_data || out_tlast !== want.last) begin
            mismatches++;
            if (mismatches <= REPORT_MAX) begin
              $display("%0t token mismatch, expected kind %0d start %0d end %0d tag %h last %b",
                       $time, want.kind, want.start_off, want.end_off, want.tag, want.last);
              $display("%0t                 actual kind %0d start %0d end %0d tag %h last %b",
                       $time, out_tdata[4:0], out_tdata[20:5], out_tdata[36:21],
                       out_tdata[52:37], out_tlast);
            end
          end
        end
      end
    end
  end

  // result side ready, random stalls plus an occasional long hold-off
  initial begin : receiver
    int hold_left;
    hold_left  = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else begin
        out_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------- drivers

  // one request; entered and left at a falling edge, valid left high
  task automatic send_req(input logic act, input logic [7:0] c);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= c;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    reqs_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_req(ACT_BYTE, s[i]);
  endtask

  // stop offering and wait for every predicted token
  task automatic drain_requests();
    in_tvalid <= 1'b0;
    while (expected_tokens.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_tag(input logic [15:0] v);
    cfg_wr_data <= v;
    cfg_wr_en   <= 1'b1;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    @(negedge clk);
  endtask

  // one random lexeme, mostly well formed, some noise and end markers
  task automatic send_lexeme();
    int    pick;
    int    variant;
    int    n;
    int    i;
    string w;
    pick = $urandom_range(99);
    if (pick < 14) begin
      // keyword, a proper prefix of one, or one with a tail
      w = kw_word($urandom_range(4));
      variant = $urandom_range(3);
      for (i = 0; i < w.len() - (variant == 0 ? 1 : 0); i++) send_req(ACT_BYTE, w[i]);
      if (variant == 1) send_req(ACT_BYTE, ident_chars[$urandom_range(62)]);
    end else if (pick < 30) begin
      n = $urandom_range(1, 10);
      send_req(ACT_BYTE, ident_chars[$urandom_range(52)]);
      for (i = 1; i < n; i++) send_req(ACT_BYTE, ident_chars[$urandom_range(62)]);
    end else if (pick < 42) begin
      n = $urandom_range(1, 5);
      for (i = 0; i < n; i++) send_req(ACT_BYTE, 8'(8'h30 + $urandom_range(9)));
    end else if (pick < 55) begin
      send_req(ACT_BYTE, punct_chars[$urandom_range(8)]);
    end else if (pick < 65) begin
      send_req(ACT_BYTE, op_chars[$urandom_range(3)]);
      send_req(ACT_BYTE, "=");
    end else if (pick < 72) begin
      send_req(ACT_BYTE, op_chars[$urandom_range(3)]);
    end else if (pick < 88) begin
      n = $urandom_range(1, 3);
      for (i = 0; i < n; i++) begin
        case ($urandom_range(3))
          0:       send_req(ACT_BYTE, 8'h20);
          1:       send_req(ACT_BYTE, 8'h09);
          2:       send_req(ACT_BYTE, 8'h0D);
          default: send_req(ACT_BYTE, 8'h0A);
        endcase
      end
    end else if (pick < 96) begin
      send_req(ACT_BYTE, 8'($urandom_range(255)));
    end else begin
      send_req(ACT_END, 8'($urandom_range(255)));
    end
  endtask

  // ---------------------------------------------------------------- tests

  // end marker straight after reset, tag still at its reset value
  task automatic test_eof_when_idle();
    send_req(ACT_END, 8'h00);
    drain_requests();
  endtask

  // nul, top byte, lone bang, over-long identifier, operator tails, flush at end
  task automatic test_odd_bytes();
    send_req(ACT_BYTE, 8'h00);
    send_req(ACT_BYTE, 8'hFF);
    send_req(ACT_BYTE, "!");
    send_req(ACT_BYTE, 8'h20);
    send_text("whilexyz");
    send_req(ACT_BYTE, ">");
    send_text("fn=7");
    send_req(ACT_END, 8'hFF);
    drain_requests();
  endtask

  task automatic test_random_source(input int n_req);
    int first;
    first = reqs_sent;
    while (reqs_sent - first < n_req) send_lexeme();
    send_req(ACT_END, 8'($urandom_range(255)));
    drain_requests();
  endtask

  // receiver holds off while single byte tokens keep coming
  task automatic test_receiver_hold();
    int i;
    hold_req = 300;
    for (i = 0; i < 40; i++) begin
      if ($urandom_range(3) == 0) send_req(ACT_BYTE, 8'($urandom_range(128, 255)));
      else send_req(ACT_BYTE, punct_chars[$urandom_range(8)]);
    end
    send_req(ACT_END, 8'h00);
    drain_requests();
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = 8'h00;
    in_tuser    = ACT_BYTE;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = 16'h0000;
    mismatches  = 0;
    reqs_sent   = 0;
    hold_req    = 0;
    tx_idle_pct = 38;
    rx_idle_pct = 49;
    src_tag     = 16'h0000;
    clear_lexer();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_eof_when_idle();
    write_tag(16'hFFFF);
    test_odd_bytes();
    write_tag(16'($urandom_range(65535)));
    test_random_source(280);

    tx_idle_pct = 49;
    rx_idle_pct = 38;
    write_tag(16'h0000);
    test_random_source(280);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_tag(16'($urandom_range(65535)));
    test_random_source(280);
    write_tag(16'h8001);
    test_receiver_hold();

    drain_requests();
    if (mismatches == 0 && expected_tokens.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* files.f */
hdl/stl_pkg.sv
hdl/stl_lex_core.sv
hdl/stl_out_queue.sv
hdl/script_token_lexer.sv
tb/tb_script_token_lexer.sv
